// File: rtl/sor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR pressure solver package
// Shared constants, types and saturation helpers.
// ----------------------------------------------------------------------------
package sor_pkg;

  localparam int MAX_INTERIOR_DEF = 64;
  localparam int MAX_SWEEPS_DEF   = 10000;
  localparam logic [63:0] TOL_SQ  = 64'd43;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_SOLVE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_COLS  = 3'd0,
    CFG_ROWS  = 3'd1,
    CFG_KEEP  = 3'd2,
    CFG_SCALE = 3'd3,
    CFG_IDX2  = 3'd4,
    CFG_IDY2  = 3'd5,
    CFG_IDTDX = 3'd6,
    CFG_IDTDY = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STEP_DIVX  = 3'd0,
    STEP_DIVY  = 3'd1,
    STEP_LAPX  = 3'd2,
    STEP_LAPY  = 3'd3,
    STEP_KEEP  = 3'd4,
    STEP_SCALE = 3'd5,
    STEP_WB    = 3'd6
  } step_e;

  typedef struct packed {
    logic  en;
    logic  resid;
    step_e step;
  } alu_ctl_t;

  typedef struct packed {
    logic signed [31:0] pu;
    logic signed [31:0] pw;
    logic signed [31:0] pc;
    logic signed [31:0] pe;
    logic signed [31:0] pd;
    logic signed [31:0] fc;
    logic signed [31:0] fw;
    logic signed [31:0] gc;
    logic signed [31:0] gs;
  } cell_nb_t;

  function automatic logic signed [31:0] sat_sym(input logic signed [51:0] x);
    if (x > 52'sd2147483647) begin
      return 32'sd2147483647;
    end else if (x < -52'sd2147483647) begin
      return -32'sd2147483647;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    if (x > 49'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -49'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// File: rtl/sor_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR pressure solver channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sor_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [6:0]         cell_row;
  logic [6:0]         cell_col;
  logic signed [31:0] pressure_in;
  logic signed [31:0] f_in;
  logic signed [31:0] g_in;

  modport source(output valid, action, cell_row, cell_col, pressure_in, f_in, g_in,
                 input ready);
  modport sink(input valid, action, cell_row, cell_col, pressure_in, f_in, g_in,
               output ready);
endinterface

interface sor_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure_out;
  logic [13:0]        sweep_index;
  logic               converged;

  modport source(output valid, pressure_out, sweep_index, converged, input ready);
  modport sink(input valid, pressure_out, sweep_index, converged, output ready);
endinterface

// File: rtl/sor_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sor_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/sor_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR cell arithmetic
// Shared multiplier stepping through divergence, stencil and update terms.
// ----------------------------------------------------------------------------
module sor_alu
  import sor_pkg::*;
(
  input  logic               clk_i,
  input  alu_ctl_t           ctl_i,
  input  cell_nb_t           nb_i,
  input  logic signed [31:0] keep_i,
  input  logic signed [31:0] scale_i,
  input  logic [30:0]        idx2_i,
  input  logic [30:0]        idy2_i,
  input  logic [30:0]        idtdx_i,
  input  logic [30:0]        idtdy_i,
  output logic signed [31:0] p_new_o,
  output logic [63:0]        sq_o
);
  logic signed [64:0] prod_q;
  logic signed [64:0] acc_q;
  logic signed [51:0] div_q;
  logic signed [51:0] lap_q;
  logic signed [31:0] s_q;

  logic signed [31:0] opa;
  logic signed [32:0] opb;
  logic signed [48:0] fl;
  logic signed [33:0] d2x_raw;
  logic signed [33:0] d2y_raw;
  logic signed [31:0] d2x;
  logic signed [31:0] d2y;
  logic signed [31:0] s_abs;
  logic signed [64:0] upd;

  assign fl      = prod_q[64:16];
  assign d2x_raw = 34'(nb_i.pe) + 34'(nb_i.pw) - (34'(nb_i.pc) <<< 1);
  assign d2y_raw = 34'(nb_i.pu) + 34'(nb_i.pd) - (34'(nb_i.pc) <<< 1);
  assign d2x     = sat_sym(52'(d2x_raw));
  assign d2y     = sat_sym(52'(d2y_raw));
  assign s_abs   = s_q[31] ? -s_q : s_q;

  always_comb begin
    opa = '0;
    opb = '0;
    case (ctl_i.step)
      STEP_DIVX: begin
        opa = $signed({1'b0, idtdx_i});
        opb = 33'(nb_i.fc) - 33'(nb_i.fw);
      end
      STEP_DIVY: begin
        opa = $signed({1'b0, idtdy_i});
        opb = 33'(nb_i.gc) - 33'(nb_i.gs);
      end
      STEP_LAPX: begin
        opa = $signed({1'b0, idx2_i});
        opb = ctl_i.resid ? 33'(d2x) : 33'(nb_i.pe) + 33'(nb_i.pw);
      end
      STEP_LAPY: begin
        opa = $signed({1'b0, idy2_i});
        opb = ctl_i.resid ? 33'(d2y) : 33'(nb_i.pu) + 33'(nb_i.pd);
      end
      STEP_KEEP: begin
        opa = keep_i;
        opb = 33'(nb_i.pc);
      end
      STEP_SCALE: begin
        opa = ctl_i.resid ? s_abs : scale_i;
        opb = ctl_i.resid ? 33'(s_abs) : 33'(s_q);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= opa * opb;
      case (ctl_i.step)
        STEP_DIVY:  div_q <= 52'(fl);
        STEP_LAPX:  div_q <= div_q + 52'(fl);
        STEP_LAPY:  lap_q <= 52'(fl);
        STEP_KEEP:  s_q   <= sat_sym(lap_q + 52'(fl) - div_q);
        STEP_SCALE: acc_q <= prod_q;
        default: begin
        end
      endcase
    end
  end

  assign upd     = acc_q + prod_q;
  assign p_new_o = sat32(upd[64:16]);
  assign sq_o    = prod_q[63:0];
endmodule

// File: rtl/sor_pressure_poisson_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR pressure Poisson solver
// Cell write and action 3 answer in the cycle after accept; a read passes
// through the read state before its result is registered. A solve visits
// each interior cell twice per sweep (update pass, residual pass); each
// visit makes five pressure RAM reads, then seven shared multiplier steps.
// Reset returns control to idle and configuration to its defaults; grid
// memories hold no reset value.
// ----------------------------------------------------------------------------
module sor_pressure_poisson_solver_top
  import sor_pkg::*;
#(
  parameter int MAX_INTERIOR = MAX_INTERIOR_DEF,
  parameter int MAX_SWEEPS   = MAX_SWEEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sor_in_if.sink      in_ch,
  sor_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int GRID_DIM = MAX_INTERIOR + 2;
  localparam int CELLS    = GRID_DIM * GRID_DIM;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(MAX_INTERIOR + 1);
  localparam int IW       = $clog2(MAX_SWEEPS + 1);
  localparam logic [AW-1:0] DIM = AW'(GRID_DIM);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_INIT  = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_CALC  = 6'b010000,
    ST_CHECK = 6'b100000
  } state_e;

  state_e state_q;

  logic [6:0]         cols_cfg_q, rows_cfg_q;
  logic signed [31:0] keep_q, scale_q;
  logic [30:0]        idx2_q, idy2_q, idtdx_q, idtdy_q;

  logic [RW-1:0]   rows_eff, cols_eff, r_q, c_q;
  logic [AW-1:0]   base_q, k, cell_addr;
  logic [2*RW-1:0] cells_q;
  logic [IW-1:0]   it_q;
  logic [2:0]      ph_q;
  step_e           step_q;
  logic            resid_q, in_grid, in_grid_q;
  logic [63:0]     sum_q, limit;
  logic [64:0]     sum_add;
  cell_nb_t        nb_q;
  alu_ctl_t        alu_ctl;
  logic signed [31:0] p_new;
  logic [63:0]     sq;

  logic            out_valid_q, out_conv_q, out_set;
  logic [31:0]     out_pres_q;
  logic [13:0]     out_idx_q;

  logic            in_acc, p_we, fg_we;
  logic [AW-1:0]   p_raddr, f_raddr, g_raddr, p_waddr;
  logic [31:0]     p_wdata, p_rd, f_rd, g_rd;

  always_comb begin
    rows_eff = RW'(rows_cfg_q);
    cols_eff = RW'(cols_cfg_q);
    if (rows_cfg_q == 7'd0) begin
      rows_eff = RW'(1);
    end else if (32'(rows_cfg_q) > MAX_INTERIOR) begin
      rows_eff = RW'(MAX_INTERIOR);
    end
    if (cols_cfg_q == 7'd0) begin
      cols_eff = RW'(1);
    end else if (32'(cols_cfg_q) > MAX_INTERIOR) begin
      cols_eff = RW'(MAX_INTERIOR);
    end
  end

  assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_grid     = (32'(in_ch.cell_row) < GRID_DIM) && (32'(in_ch.cell_col) < GRID_DIM);
  assign cell_addr   = AW'(32'(in_ch.cell_row) * GRID_DIM + 32'(in_ch.cell_col));
  assign k           = base_q + AW'(c_q);
  assign limit       = 64'(cells_q) * TOL_SQ;
  assign sum_add     = 65'(sum_q) + 65'(sq);

  assign out_set = (in_acc && (in_ch.action != ACT_SOLVE) && (in_ch.action != ACT_READ))
                || (state_q == ST_READ)
                || ((state_q == ST_CHECK) &&
                    ((sum_q <= limit) || (32'(it_q) == MAX_SWEEPS - 1)));

  always_comb begin
    case (ph_q)
      3'd0:    p_raddr = k - DIM;
      3'd1:    p_raddr = k - AW'(1);
      3'd2:    p_raddr = k;
      3'd3:    p_raddr = k + AW'(1);
      default: p_raddr = k + DIM;
    endcase
    if (state_q == ST_IDLE) begin
      p_raddr = cell_addr;
    end
  end
  assign f_raddr = (ph_q == 3'd0) ? k : k - AW'(1);
  assign g_raddr = (ph_q == 3'd0) ? k : k - DIM;

  assign fg_we   = in_acc && (in_ch.action == ACT_WRITE) && in_grid;
  assign p_we    = fg_we || ((state_q == ST_CALC) && (step_q == STEP_WB) && !resid_q);
  assign p_waddr = (state_q == ST_IDLE) ? cell_addr : k;
  assign p_wdata = (state_q == ST_IDLE) ? in_ch.pressure_in : p_new;

  sor_ram #(.W(32), .DEPTH(CELLS)) u_p_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rd)
  );
  sor_ram #(.W(32), .DEPTH(CELLS)) u_f_ram (
    .clk_i, .we_i(fg_we), .waddr_i(cell_addr), .wdata_i(in_ch.f_in),
    .raddr_i(f_raddr), .rdata_o(f_rd)
  );
  sor_ram #(.W(32), .DEPTH(CELLS)) u_g_ram (
    .clk_i, .we_i(fg_we), .waddr_i(cell_addr), .wdata_i(in_ch.g_in),
    .raddr_i(g_raddr), .rdata_o(g_rd)
  );

  assign alu_ctl = '{en: (state_q == ST_CALC), resid: resid_q, step: step_q};

  sor_alu u_alu (
    .clk_i, .ctl_i(alu_ctl), .nb_i(nb_q), .keep_i(keep_q), .scale_i(scale_q),
    .idx2_i(idx2_q), .idy2_i(idy2_q), .idtdx_i(idtdx_q), .idtdy_i(idtdy_q),
    .p_new_o(p_new), .sq_o(sq)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH) begin
      case (ph_q)
        3'd1: begin
          nb_q.pu <= p_rd;
          nb_q.fc <= f_rd;
          nb_q.gc <= g_rd;
        end
        3'd2: begin
          nb_q.pw <= p_rd;
          nb_q.fw <= f_rd;
          nb_q.gs <= g_rd;
        end
        3'd3:    nb_q.pc <= p_rd;
        3'd4:    nb_q.pe <= p_rd;
        3'd5:    nb_q.pd <= p_rd;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= 7'd64;
      rows_cfg_q <= 7'd64;
      keep_q     <= '0;
      scale_q    <= '0;
      idx2_q     <= 31'd65536;
      idy2_q     <= 31'd65536;
      idtdx_q    <= 31'd65536;
      idtdy_q    <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COLS:  cols_cfg_q <= cfg_data_i[6:0];
        CFG_ROWS:  rows_cfg_q <= cfg_data_i[6:0];
        CFG_KEEP:  keep_q     <= cfg_data_i;
        CFG_SCALE: scale_q    <= cfg_data_i;
        CFG_IDX2:  idx2_q     <= cfg_data_i[30:0];
        CFG_IDY2:  idy2_q     <= cfg_data_i[30:0];
        CFG_IDTDX: idtdx_q    <= cfg_data_i[30:0];
        CFG_IDTDY: idtdy_q    <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_pres_q  <= '0;
      out_idx_q   <= '0;
      out_conv_q  <= 1'b0;
      in_grid_q   <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      base_q      <= '0;
      cells_q     <= '0;
      it_q        <= '0;
      ph_q        <= '0;
      step_q      <= STEP_DIVX;
      resid_q     <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            in_grid_q  <= in_grid;
            out_pres_q <= '0;
            out_idx_q  <= '0;
            out_conv_q <= 1'b0;
            case (action_e'(in_ch.action))
              ACT_SOLVE: state_q <= ST_INIT;
              ACT_READ:  state_q <= ST_READ;
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          out_pres_q <= in_grid_q ? p_rd : '0;
          state_q    <= ST_IDLE;
        end
        ST_INIT: begin
          cells_q <= rows_eff * cols_eff;
          it_q    <= '0;
          resid_q <= 1'b0;
          r_q     <= RW'(1);
          c_q     <= RW'(1);
          base_q  <= DIM;
          ph_q    <= '0;
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          ph_q <= ph_q + 3'd1;
          if (ph_q == 3'd5) begin
            step_q  <= STEP_DIVX;
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          step_q <= step_e'(step_q + 3'd1);
          if (step_q == STEP_WB) begin
            ph_q    <= '0;
            state_q <= ST_FETCH;
            if (resid_q) begin
              sum_q <= sum_add[64] ? '1 : sum_add[63:0];
            end
            if (c_q < cols_eff) begin
              c_q <= c_q + RW'(1);
            end else if (r_q < rows_eff) begin
              c_q    <= RW'(1);
              r_q    <= r_q + RW'(1);
              base_q <= base_q + DIM;
            end else begin
              c_q    <= RW'(1);
              r_q    <= RW'(1);
              base_q <= DIM;
              if (!resid_q) begin
                resid_q <= 1'b1;
                sum_q   <= '0;
              end else begin
                state_q <= ST_CHECK;
              end
            end
          end
        end
        ST_CHECK: begin
          resid_q <= 1'b0;
          ph_q    <= '0;
          if (sum_q <= limit) begin
            out_idx_q  <= 14'(32'(it_q));
            out_conv_q <= 1'b1;
            state_q    <= ST_IDLE;
          end else if (32'(it_q) == MAX_SWEEPS - 1) begin
            out_idx_q  <= 14'(MAX_SWEEPS);
            out_conv_q <= 1'b0;
            state_q    <= ST_IDLE;
          end else begin
            it_q    <= it_q + IW'(1);
            state_q <= ST_FETCH;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.pressure_out = out_pres_q;
  assign out_ch.sweep_index  = out_idx_q;
  assign out_ch.converged    = out_conv_q;

  a_p_write_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we |-> (state_q == ST_IDLE || state_q == ST_CALC))
    else $error("pressure write outside idle or update step");

  a_cell_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |->
      (r_q != '0 && r_q <= rows_eff && c_q != '0 && c_q <= cols_eff))
    else $error("sweep cell outside interior");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      $past(state_q == ST_IDLE || state_q == ST_READ || state_q == ST_CHECK))
    else $error("result beat raised from a busy state");
endmodule

// File: test/sor_solver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR pressure solver checker
// Watches the command, result and register ports, keeps its own copy of the
// grids and registers, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module sor_solver_checker
  import sor_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sor_in_if           in_ch,
  sor_out_if          out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          error_count_o,
  output int          pending_o,
  output int          solves_o,
  output int          converged_o
);

  localparam int DIM = MAX_INTERIOR_DEF + 2;
  localparam int CELLS = DIM * DIM;
  localparam int SWEEP_LIMIT = MAX_SWEEPS_DEF;
  localparam longint SYM_LIM = 64'sd2147483647;

  typedef struct packed {
    logic signed [31:0] pressure;
    logic [13:0]        sweep;
    logic               conv;
  } sor_result_t;

  sor_result_t result_q[$];

  int p_grid[CELLS];
  int f_grid[CELLS];
  int g_grid[CELLS];
  int unsigned cols_r, rows_r;
  longint keep_r, scale_r, idx2_r, idy2_r, idtdx_r, idtdy_r;
  longint unsigned resid_r;

  function automatic longint clip_sym(longint x);
    if (x > SYM_LIM) return SYM_LIM;
    if (x < -SYM_LIM) return -SYM_LIM;
    return x;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic int clamp_n(int unsigned n);
    if (n < 1) return 1;
    if (n > DIM - 2) return DIM - 2;
    return n;
  endfunction

  function automatic longint div_src(int k);
    longint df, dg;
    df = longint'(f_grid[k]) - longint'(f_grid[k - 1]);
    dg = longint'(g_grid[k]) - longint'(g_grid[k - DIM]);
    return ((idtdx_r * df) >>> 16) + ((idtdy_r * dg) >>> 16);
  endfunction

  function automatic void relax_pass(int rows, int cols);
    int k;
    longint sx, sy, s, acc;
    for (int r = 1; r <= rows; r++) begin
      for (int c = 1; c <= cols; c++) begin
        k = r * DIM + c;
        sx = longint'(p_grid[k + 1]) + longint'(p_grid[k - 1]);
        sy = longint'(p_grid[k + DIM]) + longint'(p_grid[k - DIM]);
        s = clip_sym(((idx2_r * sx) >>> 16) + ((idy2_r * sy) >>> 16) - div_src(k));
        acc = keep_r * longint'(p_grid[k]) + scale_r * s;
        p_grid[k] = int'(clip32(acc >>> 16));
      end
    end
  endfunction

  function automatic longint unsigned residual_of(int rows, int cols);
    longint unsigned sum, sq;
    longint pc2, d2x, d2y, t;
    int k;
    sum = 0;
    for (int r = 1; r <= rows; r++) begin
      for (int c = 1; c <= cols; c++) begin
        k = r * DIM + c;
        pc2 = 2 * longint'(p_grid[k]);
        d2x = clip_sym(longint'(p_grid[k + 1]) - pc2 + longint'(p_grid[k - 1]));
        d2y = clip_sym(longint'(p_grid[k + DIM]) - pc2 + longint'(p_grid[k - DIM]));
        t = clip_sym(((idx2_r * d2x) >>> 16) + ((idy2_r * d2y) >>> 16) - div_src(k));
        if (t < 0) t = -t;
        sq = longint'(t) * longint'(t);
        if (sum > 64'hffff_ffff_ffff_ffff - sq) sum = 64'hffff_ffff_ffff_ffff;
        else sum += sq;
      end
    end
    return sum;
  endfunction

  function automatic sor_result_t predict_beat(logic [1:0] act, int unsigned row,
                                               int unsigned col, int pv, int fv, int gv);
    sor_result_t res;
    logic in_grid;
    int k, rows, cols, n;
    longint unsigned limit;
    bit done;
    res = '0;
    in_grid = (row < DIM) && (col < DIM);
    k = in_grid ? row * DIM + col : 0;
    if (act == ACT_WRITE) begin
      if (in_grid) begin
        p_grid[k] = pv;
        f_grid[k] = fv;
        g_grid[k] = gv;
      end
    end else if (act == ACT_SOLVE) begin
      rows = clamp_n(rows_r);
      cols = clamp_n(cols_r);
      limit = TOL_SQ * longint'(rows * cols);
      done = 0;
      for (n = 0; n < SWEEP_LIMIT; n++) begin
        relax_pass(rows, cols);
        resid_r = residual_of(rows, cols);
        if (resid_r <= limit) begin
          done = 1;
          break;
        end
      end
      res.sweep = done ? n[13:0] : 14'(SWEEP_LIMIT);
      res.conv = done;
      solves_o++;
      if (done) converged_o++;
    end else if (act == ACT_READ) begin
      if (in_grid) res.pressure = p_grid[k];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sor_result_t got, want;
    if (!rst_ni) begin
      cols_r = 64;
      rows_r = 64;
      keep_r = 0;
      scale_r = 0;
      idx2_r = 65536;
      idy2_r = 65536;
      idtdx_r = 65536;
      idtdy_r = 65536;
      resid_r = 0;
      result_q.delete();
      error_count_o = 0;
      pending_o <= 0;
      solves_o = 0;
      converged_o = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.pressure = out_ch.pressure_out;
        got.sweep = out_ch.sweep_index;
        got.conv = out_ch.converged;
        if (result_q.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10)
            $display("%t: unexpected result beat p=%h sweep=%0d conv=%b", $realtime,
                     got.pressure, got.sweep, got.conv);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            error_count_o++;
            if (error_count_o <= 10)
              $display("%t: mismatch p exp %h got %h, sweep exp %0d got %0d, conv exp %b got %b",
                       $realtime, want.pressure, got.pressure, want.sweep, got.sweep,
                       want.conv, got.conv);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        result_q.insert(result_q.size(),
                        predict_beat(in_ch.action, in_ch.cell_row, in_ch.cell_col,
                                     in_ch.pressure_in, in_ch.f_in, in_ch.g_in));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COLS:  cols_r = cfg_data_i[6:0];
          CFG_ROWS:  rows_r = cfg_data_i[6:0];
          CFG_KEEP:  keep_r = longint'(signed'(cfg_data_i));
          CFG_SCALE: scale_r = longint'(signed'(cfg_data_i));
          CFG_IDX2:  idx2_r = longint'(cfg_data_i[30:0]);
          CFG_IDY2:  idy2_r = longint'(cfg_data_i[30:0]);
          CFG_IDTDX: idtdx_r = longint'(cfg_data_i[30:0]);
          CFG_IDTDY: idtdy_r = longint'(cfg_data_i[30:0]);
          default: ;
        endcase
      end
      pending_o <= result_q.size();
    end
  end

endmodule

// File: test/tb_sor_pressure_poisson_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR pressure solver testbench
// Loads small grid regions, reads cells and runs solves under several register
// settings with random gaps on both channels; a checker predicts each result.
// ----------------------------------------------------------------------------
module tb_sor_pressure_poisson_solver_top;
  import sor_pkg::*;

  localparam int DIM = MAX_INTERIOR_DEF + 2;
  localparam int WATCHDOG = 1500000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int          error_count, pending, solves, converged;
  int          beats_sent, idle_cycles, out_stall;
  bit          written[DIM][DIM];
  bit          no_gaps;
  int          region_rows, region_cols, phase_mode;

  sor_in_if  in_ch();
  sor_out_if out_ch();

  sor_pressure_poisson_solver_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  sor_solver_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .error_count_o(error_count),
    .pending_o    (pending),
    .solves_o     (solves),
    .converged_o  (converged)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 7) == 0)
        out_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("tb_sor_pressure_poisson_solver_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int small_val();
    return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
  endfunction

  task automatic send_beat(action_e act, int row, int col, int pv, int fv, int gv);
    int n;
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.cell_row <= row[6:0];
    in_ch.cell_col <= col[6:0];
    in_ch.pressure_in <= pv;
    in_ch.f_in <= fv;
    in_ch.g_in <= gv;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
    if (act == ACT_WRITE && row < DIM && col < DIM) written[row][col] = 1;
    n = $urandom_range(0, 99);
    if (!no_gaps && n >= 70) begin
      in_ch.valid <= 1'b0;
      repeat ((n >= 95) ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_region(int rows, int cols, bit zeros, bit full);
    for (int r = 0; r <= rows + 1; r++) begin
      for (int c = 0; c <= cols + 1; c++) begin
        if (zeros) send_beat(ACT_WRITE, r, c, 0, 0, 0);
        else if (full) send_beat(ACT_WRITE, r, c, $urandom, $urandom, $urandom);
        else send_beat(ACT_WRITE, r, c, small_val(), small_val(), small_val());
      end
    end
  endtask

  task automatic random_beat();
    int sel, row, col, pv;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        row = $urandom_range(0, region_rows + 1);
        col = $urandom_range(0, region_cols + 1);
        if (phase_mode == 0) begin
          send_beat(ACT_WRITE, row, col, small_val(), small_val(), small_val());
        end else begin
          pv = (row >= 1 && row <= region_rows && col >= 1 && col <= region_cols)
               ? small_val() : 0;
          send_beat(ACT_WRITE, row, col, pv, 0, 0);
        end
      end else if (sel < 9) begin
        send_beat(ACT_WRITE, $urandom_range(4, DIM - 1), $urandom_range(0, DIM - 1),
                  $urandom, $urandom, $urandom);
      end else begin
        send_beat(ACT_WRITE, $urandom_range(DIM, 127), $urandom_range(0, 127),
                  $urandom, $urandom, $urandom);
      end
    end else if (sel < 80) begin
      if ($urandom_range(0, 9) < 7) begin
        row = $urandom_range(0, DIM - 1);
        col = $urandom_range(0, DIM - 1);
        if (!written[row][col]) begin
          row = $urandom_range(0, region_rows + 1);
          col = $urandom_range(0, region_cols + 1);
        end
      end else begin
        row = $urandom_range(0, 127);
        col = $urandom_range(DIM, 127);
        if ($urandom_range(0, 1)) begin
          pv = row;
          row = col;
          col = pv;
        end
      end
      send_beat(ACT_READ, row, col, $urandom, $urandom, $urandom);
    end else if (sel < 93) begin
      send_beat(ACT_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom, $urandom, $urandom);
    end else begin
      send_beat(ACT_NOP, $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COLS;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.cell_row = '0;
    in_ch.cell_col = '0;
    in_ch.pressure_in = '0;
    in_ch.f_in = '0;
    in_ch.g_in = '0;
    out_ch.ready = 1'b0;
    out_stall = 0;
    idle_cycles = 0;
    beats_sent = 0;
    no_gaps = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, every action, out-of-grid cells, one plain solve.
    set_reg(CFG_COLS, 32'd1);
    set_reg(CFG_ROWS, 32'd1);
    set_reg(CFG_KEEP, 32'd0);
    set_reg(CFG_SCALE, 32'd16384);
    set_reg(CFG_IDX2, 32'd65536);
    set_reg(CFG_IDY2, 32'd65536);
    set_reg(CFG_IDTDX, 32'd65536);
    set_reg(CFG_IDTDY, 32'd65536);
    send_beat(ACT_WRITE, 0, DIM - 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_beat(ACT_WRITE, DIM - 1, DIM - 1, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_beat(ACT_WRITE, 127, 127, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_beat(ACT_WRITE, 5, DIM, 32'h1234, 32'h1, 32'h2);
    send_beat(ACT_READ, 0, DIM - 1, 0, 0, 0);
    send_beat(ACT_READ, DIM - 1, DIM - 1, 0, 0, 0);
    send_beat(ACT_READ, 127, 127, 0, 0, 0);
    send_beat(ACT_READ, 5, DIM, 0, 0, 0);
    send_beat(ACT_NOP, 127, 127, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    load_region(1, 1, 0, 0);
    send_beat(ACT_SOLVE, 0, 0, 0, 0, 0);
    send_beat(ACT_READ, 1, 1, 0, 0, 0);

    // Cell counts out of range: zero rows acts as one, too many columns as the maximum.
    drain();
    set_reg(CFG_COLS, 32'd127);
    set_reg(CFG_ROWS, 32'd0);
    set_reg(CFG_SCALE, 32'd0);
    no_gaps = 1;
    load_region(1, DIM - 2, 1, 0);
    no_gaps = 0;
    send_beat(ACT_SOLVE, 0, 0, 0, 0, 0);
    send_beat(ACT_READ, 1, DIM - 2, 0, 0, 0);

    // Register extremes on one cell with raw grid values.
    drain();
    set_reg(CFG_COLS, 32'd0);
    set_reg(CFG_ROWS, 32'd1);
    set_reg(CFG_KEEP, 32'h80000000);
    set_reg(CFG_SCALE, 32'h7fffffff);
    set_reg(CFG_IDX2, 32'h7fffffff);
    set_reg(CFG_IDY2, 32'd0);
    set_reg(CFG_IDTDX, 32'hffffffff);
    set_reg(CFG_IDTDY, 32'd0);
    load_region(1, 1, 0, 1);
    send_beat(ACT_SOLVE, 0, 0, 0, 0, 0);
    send_beat(ACT_READ, 1, 1, 0, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      phase_mode = ph % 2;
      no_gaps = (ph == 3);
      if (phase_mode == 0) begin
        region_rows = 1;
        region_cols = 1;
        set_reg(CFG_KEEP, 32'd0);
        set_reg(CFG_SCALE, 32'd16384);
      end else begin
        region_rows = $urandom_range(1, 2);
        region_cols = $urandom_range(1, 2);
        set_reg(CFG_KEEP, 32'd0);
        set_reg(CFG_SCALE, 32'd0);
      end
      set_reg(CFG_ROWS, region_rows);
      set_reg(CFG_COLS, region_cols);
      set_reg(CFG_IDX2, 32'd65536);
      set_reg(CFG_IDY2, 32'd65536);
      set_reg(CFG_IDTDX, $urandom_range(0, 2 ** 17));
      set_reg(CFG_IDTDY, $urandom_range(0, 2 ** 17));
      if (phase_mode == 0) begin
        load_region(region_rows, region_cols, 0, 0);
      end else begin
        load_region(region_rows, region_cols, 1, 0);
      end
      for (int i = 0; i < 110; i++) random_beat();
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d command beats over directed, clamped-size, extreme-register and",
             beats_sent);
    $display("five random phases; %0d solves ran, %0d of them converged.", solves, converged);
    if (error_count == 0) begin
      $display("tb_sor_pressure_poisson_solver_top: done, clean");
    end else begin
      $display("tb_sor_pressure_poisson_solver_top: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sor_pkg.sv
rtl/sor_if.sv
rtl/sor_ram.sv
rtl/sor_alu.sv
rtl/sor_pressure_poisson_solver_top.sv
test/sor_solver_checker.sv
test/tb_sor_pressure_poisson_solver_top.sv
